FILE: rtl/powered_sigmoid_activation_assert.svh
// assertion macros for the powered sigmoid activation block
// expects clk and rst_n in the scope of each use
`ifndef POWERED_SIGMOID_ACTIVATION_ASSERT_SVH
`define POWERED_SIGMOID_ACTIVATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define PSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("powered sigmoid activation check failed");
// checked on every edge, reset included
`define PSA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("powered sigmoid activation reset check failed");
`else
`define PSA_ASSERT(lbl, prop)
`define PSA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/psa_pkg.sv
// shared types, constants and latencies of the powered sigmoid activation
// no dependencies
package psa_pkg;

  localparam int IN_WIDTH     = 16;
  localparam int Q_W          = 33;   // q0.32 values up to and including 1.0
  localparam int T_W          = 64;   // unsigned q32.32 exponent argument
  localparam int SUM_W        = 34;
  localparam int LOGN_W       = 38;   // -log2 result, q6.32
  localparam int EXP_W        = 16;
  localparam int SERIES_TERMS = 24;
  localparam int RCP_SH       = 36;   // reciprocal scale for divide by term index
  localparam int CFG_IDX_W    = 2;

  localparam logic [Q_W-1:0]   ONE_Q32   = 33'h1_0000_0000;
  localparam logic [32:0]      LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0]      LN2_Q32   = 32'd2977044472;
  localparam logic [EXP_W-1:0] EXP_ONE   = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_B = 2'd1;

  // pipeline depths
  localparam int EX_LAT  = 3 * SERIES_TERMS - 1;
  localparam int NL_LAT  = 39;
  localparam int DIV_LAT = 34;
  localparam int POW_LAT = NL_LAT + 1 + EX_LAT + 1;

  typedef struct packed {
    logic             v;
    logic             z;
    logic [5:0]       n;
    logic [31:0]      g;
    logic [SUM_W-1:0] sum;
    logic [31:0]      term;
    logic [31:0]      aux;
  } ex_t;

  typedef struct packed {
    logic        v;
    logic        zf;
    logic [4:0]  k;
    logic [31:0] m;
    logic [31:0] f;
  } nl_t;

  typedef struct packed {
    logic        v;
    logic        nb;
    logic [33:0] d;
    logic [33:0] r;
    logic [32:0] q;
  } dv_t;

endpackage

FILE: rtl/psa_exp2.sv
// pipelined 2^-t for unsigned q32.32 t, result q0.32
// depends on psa_pkg
module psa_exp2 import psa_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [T_W-1:0] in_t,
  output logic           out_valid,
  output logic [Q_W-1:0] out_e
);

  ex_t ent_r, ent_nxt;
  ex_t term_chain [1:SERIES_TERMS];
  logic [63:0] g_prod;
  logic [T_W-33:0] t_hi;
  logic [Q_W-1:0] e_r, e_nxt;
  logic           v_r;
  logic [SUM_W-1:0] shifted;

  // g = frac * ln2, first series term is g itself
  always_comb begin
    t_hi = in_t[T_W-1:32];
    g_prod = 64'(in_t[31:0]) * 64'(LN2_Q32);
    ent_nxt.v    = in_valid;
    ent_nxt.z    = (t_hi >= (T_W-32)'(33));
    ent_nxt.n    = t_hi[5:0];
    ent_nxt.g    = g_prod[63:32];
    ent_nxt.sum  = SUM_W'(ONE_Q32) - SUM_W'(g_prod[63:32]);
    ent_nxt.term = g_prod[63:32];
    ent_nxt.aux  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.v <= 1'b0;
    end else if (en) begin
      ent_r <= ent_nxt;
    end
  end

  assign term_chain[1] = ent_r;

  for (genvar k = 2; k <= SERIES_TERMS; k++) begin : g_term
    localparam logic [RCP_SH-1:0] RCP = RCP_SH'((64'd1 << RCP_SH) / k);
    localparam logic [4:0] KV = 5'(k);
    localparam bit ODD = (k % 2) == 1;
    ex_t a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
    logic [63:0] pa;
    logic [67:0] pb;
    logic [36:0] qk;
    logic [36:0] rem;
    logic [31:0] q;

    // term times g
    always_comb begin
      pa = 64'(term_chain[k-1].term) * 64'(term_chain[k-1].g);
      a_nxt = term_chain[k-1];
      a_nxt.term = pa[63:32];
    end

    // quotient estimate, at most one low
    always_comb begin
      pb = 68'(a_r.term) * 68'(RCP);
      b_nxt = a_r;
      b_nxt.aux = pb[67:36];
    end

    // fix the quotient, then add or subtract the term
    always_comb begin
      qk  = 37'(b_r.aux) * 37'(KV);
      rem = 37'(b_r.term) - qk;
      q   = b_r.aux + 32'(rem >= 37'(KV));
      c_nxt = b_r;
      c_nxt.term = q;
      c_nxt.aux  = '0;
      if (ODD) begin
        c_nxt.sum = (SUM_W'(q) > b_r.sum) ? '0 : b_r.sum - SUM_W'(q);
      end else begin
        c_nxt.sum = b_r.sum + SUM_W'(q);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_r.v <= 1'b0;
        b_r.v <= 1'b0;
        c_r.v <= 1'b0;
      end else if (en) begin
        a_r <= a_nxt;
        b_r <= b_nxt;
        c_r <= c_nxt;
      end
    end

    assign term_chain[k] = c_r;
  end

  always_comb begin
    shifted = term_chain[SERIES_TERMS].sum >> term_chain[SERIES_TERMS].n;
    e_nxt = term_chain[SERIES_TERMS].z ? '0 : shifted[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= term_chain[SERIES_TERMS].v;
      e_r <= e_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_e     = e_r;

endmodule

FILE: rtl/psa_nlog2.sv
// pipelined -log2(v) for q0.32 v, result q6.32, zero for v of 0 or 1.0
// depends on psa_pkg
module psa_nlog2 import psa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [Q_W-1:0]    in_v,
  output logic              out_valid,
  output logic [LOGN_W-1:0] out_l
);

  nl_t norm_chain [0:5];
  nl_t sq_chain   [0:32];
  nl_t ent_r, ent_nxt;
  logic              v_r;
  logic [LOGN_W-1:0] l_r, l_nxt;

  always_comb begin
    ent_nxt.v  = in_valid;
    ent_nxt.zf = (in_v == '0) || in_v[Q_W-1];
    ent_nxt.k  = '0;
    ent_nxt.m  = in_v[31:0];
    ent_nxt.f  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.v <= 1'b0;
    end else if (en) begin
      ent_r <= ent_nxt;
    end
  end

  assign norm_chain[0] = ent_r;

  // leading zero normalization, one shift size per stage
  for (genvar j = 0; j < 5; j++) begin : g_norm
    localparam int SH = 16 >> j;
    nl_t s_r, s_nxt;
    always_comb begin
      s_nxt = norm_chain[j];
      if (norm_chain[j].m[31 -: SH] == '0) begin
        s_nxt.m = norm_chain[j].m << SH;
        s_nxt.k = norm_chain[j].k + 5'(SH);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_r.v <= 1'b0;
      end else if (en) begin
        s_r <= s_nxt;
      end
    end
    assign norm_chain[j+1] = s_r;
  end

  assign sq_chain[0] = norm_chain[5];

  // one fraction bit per squaring
  for (genvar i = 0; i < 32; i++) begin : g_sq
    nl_t s_r, s_nxt;
    logic [63:0] sq;
    logic [32:0] t;
    always_comb begin
      sq = 64'(sq_chain[i].m) * 64'(sq_chain[i].m);
      t  = sq[63:31];
      s_nxt = sq_chain[i];
      if (t[32]) begin
        s_nxt.m = t[32:1];
        s_nxt.f = {sq_chain[i].f[30:0], 1'b1};
      end else begin
        s_nxt.m = t[31:0];
        s_nxt.f = {sq_chain[i].f[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_r.v <= 1'b0;
      end else if (en) begin
        s_r <= s_nxt;
      end
    end
    assign sq_chain[i+1] = s_r;
  end

  always_comb begin
    l_nxt = {6'(sq_chain[32].k) + 6'd1, 32'd0} - {6'd0, sq_chain[32].f};
    if (sq_chain[32].zf) begin
      l_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= sq_chain[32].v;
      l_r <= l_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_l     = l_r;

endmodule

FILE: rtl/psa_div.sv
// sigmoid divider: 2^64 / (1 + e) or min(e, 1 - ulp) / (1 + e), q0.32 out
// depends on psa_pkg, restoring division one quotient bit per stage
module psa_div import psa_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic           in_neg,
  input  logic [Q_W-1:0] in_e,
  output logic           out_valid,
  output logic [Q_W-1:0] out_s
);

  dv_t chain [0:33];
  dv_t ent_r, ent_nxt;
  logic [31:0] e_clip;

  always_comb begin
    e_clip = in_e[Q_W-1] ? 32'hFFFF_FFFF : in_e[31:0];
    ent_nxt.v = in_valid;
    ent_nxt.d = 34'(ONE_Q32) + 34'(in_e);
    ent_nxt.q = '0;
    if (in_neg) begin
      ent_nxt.r  = 34'(e_clip[31:1]);
      ent_nxt.nb = e_clip[0];
    end else begin
      ent_nxt.r  = 34'h0_8000_0000;
      ent_nxt.nb = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.v <= 1'b0;
    end else if (en) begin
      ent_r <= ent_nxt;
    end
  end

  assign chain[0] = ent_r;

  for (genvar j = 0; j < 33; j++) begin : g_bit
    localparam int BI = 32 - j;
    dv_t s_r, s_nxt;
    logic [34:0] r2;
    logic        ge;
    always_comb begin
      r2 = {chain[j].r, (BI == 32) ? chain[j].nb : 1'b0};
      ge = r2 >= {1'b0, chain[j].d};
      s_nxt = chain[j];
      s_nxt.r = ge ? 34'(r2 - {1'b0, chain[j].d}) : r2[33:0];
      s_nxt.q[BI] = ge;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_r.v <= 1'b0;
      end else if (en) begin
        s_r <= s_nxt;
      end
    end
    assign chain[j+1] = s_r;
  end

  assign out_valid = chain[33].v;
  assign out_s     = chain[33].q;

endmodule

FILE: rtl/psa_pow.sv
// v^E for q0.32 v and q8.8 E as 2^-(-log2(v) * E)
// depends on psa_pkg, psa_nlog2, psa_exp2
module psa_pow import psa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [Q_W-1:0]   in_v,
  input  logic [EXP_W-1:0] exponent,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_p
);

  localparam int ZD = NL_LAT + 1 + EX_LAT;

  logic              l_valid;
  logic [LOGN_W-1:0] l_val;
  logic [LOGN_W+EXP_W-1:0] lp;
  logic              mv_r;
  logic [T_W-1:0]    mt_r, mt_nxt;
  logic              e_valid;
  logic [Q_W-1:0]    e_val;
  logic [ZD-1:0]     zd_r;
  logic              p_v_r;
  logic [Q_W-1:0]    p_r, p_nxt;

  psa_nlog2 u_nlog2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_v      (in_v),
    .out_valid (l_valid),
    .out_l     (l_val)
  );

  always_comb begin
    lp = (LOGN_W+EXP_W)'(l_val) * (LOGN_W+EXP_W)'(exponent);
    mt_nxt = T_W'(lp[LOGN_W+EXP_W-1:8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= l_valid;
      mt_r <= mt_nxt;
    end
  end

  psa_exp2 u_exp2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mv_r),
    .in_t      (mt_r),
    .out_valid (e_valid),
    .out_e     (e_val)
  );

  // zero base flag rides alongside the log and exp pipes
  always_ff @(posedge clk) begin
    if (en) begin
      zd_r <= {zd_r[ZD-2:0], in_v == '0};
    end
  end

  always_comb begin
    if (exponent == '0) begin
      p_nxt = ONE_Q32;
    end else if (zd_r[ZD-1]) begin
      p_nxt = '0;
    end else begin
      p_nxt = e_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= e_valid;
      p_r   <= p_nxt;
    end
  end

  assign out_valid = p_v_r;
  assign out_p     = p_r;

endmodule

FILE: rtl/powered_sigmoid_activation.sv
// top level of the powered sigmoid activation y = 1 - (1 - sigmoid(x)^A)^B
// depends on psa_pkg, psa_exp2, psa_div, psa_pow, powered_sigmoid_activation_assert.svh
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_x_in, signed q4.12
//  out     | output    | out_valid/out_stall | out_y_out, unsigned q0.16
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (q8.8 exponents)
//
// one item enters per clock unless a held output stalls the pipe; the two power units
// (log2 squaring chain plus 24-term exp series each) follow the sigmoid and divider
// synchronous active-low reset clears all valid bits and sets both exponents to 1.0
// a stall while the output holds a valid result freezes the whole pipe, so in_stall follows it in the same cycle
// configuration writes are always taken (cfg_ready tied high)
`include "powered_sigmoid_activation_assert.svh"

module powered_sigmoid_activation import psa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_WIDTH-1:0]  in_x_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_y_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EXP_W-1:0]     cfg_data
);

  localparam int MW = IN_WIDTH + 33;

  logic                 en;
  logic [EXP_W-1:0]     exp_a_r;
  logic [EXP_W-1:0]     exp_b_r;

  // sigmoid front end
  logic                 neg;
  logic [IN_WIDTH-1:0]  mag;
  logic [MW-1:0]        mag_prod;
  logic                 sg_v_r;
  logic                 sg_neg_r;
  logic [T_W-1:0]       sg_t_r, sg_t_nxt;
  logic                 e_valid;
  logic [Q_W-1:0]       e_val;
  logic [EX_LAT-1:0]    neg_dly_r;
  logic                 s_valid;
  logic [Q_W-1:0]       s_val;

  // power stages
  logic                 u_valid;
  logic [Q_W-1:0]       u_val;
  logic                 w_valid;
  logic [Q_W-1:0]       w_val;

  // output register
  logic [Q_W-1:0]       y32;
  logic [Q_W:0]         y_rnd;
  logic [15:0]          y_nxt;
  logic                 out_valid_r;
  logic [15:0]          out_y_r;

  // whole pipe moves unless a finished result is held up
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_a_r <= EXP_ONE;
      exp_b_r <= EXP_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXP_A: exp_a_r <= cfg_data;
        REG_EXP_B: exp_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // |x| * log2(e), q32.32
  always_comb begin
    neg      = in_x_in[IN_WIDTH-1];
    mag      = neg ? (~in_x_in + 1'b1) : in_x_in;
    mag_prod = MW'(mag) * MW'(LOG2E_Q32);
    sg_t_nxt = T_W'(mag_prod[MW-1:12]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_v_r <= 1'b0;
    end else if (en) begin
      sg_v_r   <= in_valid;
      sg_neg_r <= neg;
      sg_t_r   <= sg_t_nxt;
    end
  end

  // e = exp(-|x|)
  psa_exp2 u_sig_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sg_v_r),
    .in_t      (sg_t_r),
    .out_valid (e_valid),
    .out_e     (e_val)
  );

  // sign rides along with the exp pipe
  always_ff @(posedge clk) begin
    if (en) begin
      neg_dly_r <= {neg_dly_r[EX_LAT-2:0], sg_neg_r};
    end
  end

  // s = sigmoid(x) in q0.32
  psa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_valid),
    .in_neg    (neg_dly_r[EX_LAT-1]),
    .in_e      (e_val),
    .out_valid (s_valid),
    .out_s     (s_val)
  );

  // u = s^A
  psa_pow u_pow_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_v      (s_val),
    .exponent  (exp_a_r),
    .out_valid (u_valid),
    .out_p     (u_val)
  );

  // w = (1 - u)^B
  psa_pow u_pow_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (u_valid),
    .in_v      (ONE_Q32 - u_val),
    .exponent  (exp_b_r),
    .out_valid (w_valid),
    .out_p     (w_val)
  );

  // y = 1 - w, rounded half up to q0.16 and saturated
  always_comb begin
    y32   = ONE_Q32 - w_val;
    y_rnd = (Q_W+1)'(y32) + (Q_W+1)'(17'h08000);
    y_nxt = (y_rnd[Q_W:16] > 18'h0FFFF) ? 16'hFFFF : y_rnd[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= w_valid;
      out_y_r     <= y_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_y_out = out_y_r;

  // reset empties the output stage
  `PSA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)
  // sigmoid never exceeds 1.0
  `PSA_ASSERT(a_sig_range, s_valid |-> (s_val <= ONE_Q32))
  // outer exponent zero forces a zero result
  `PSA_ASSERT(a_b_zero, (w_valid && exp_b_r == '0) |-> (y_nxt == 16'h0000))
  // inner exponent zero with nonzero outer exponent saturates
  `PSA_ASSERT(a_a_zero, (w_valid && exp_a_r == '0 && exp_b_r != '0) |-> (y_nxt == 16'hFFFF))

endmodule
